[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");

`endif

[sv/prq_pkg.sv]
// Package for the pending request queue: sizes, commands and status codes.
package prq_pkg;
	localparam int QUEUE_DEPTH = 32;
	localparam int ID_WIDTH    = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_TAKE   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_MARK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;
endpackage

[sv/pending_request_queue_with_cancel.sv]
// Pending request queue with cancel: bounded FIFO with remove and mark by id.
// An add writes the id at the tail; a take skips dead entries at the head one by one and
// returns the first live id; mark and remove scan from the head until the id matches or
// the occupancy is reached, and a remove then moves each younger entry down one place.
// One word in flight; a held result stalls input, as the next word waits until it is taken.
// Reset clears count, head, dead bits and limit (to 16); the id RAM is not reset.
`include "assert_macros.svh"
module pending_request_queue_with_cancel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [15:0]                   circuit_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [15:0]                   taken_id,
	output logic [5:0]                    occupancy,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata
);
	import prq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ADD, S_TAKE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_DONE
	} state_t;

	logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] rd_data_q;
	logic                rd_en;
	logic [PTR_W-1:0]    rd_addr;
	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	logic [ID_WIDTH-1:0] wr_data;

	state_t              state_q;
	logic [QUEUE_DEPTH-1:0] dead_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [5:0]          limit_q;
	cmd_t                cmd_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [CNT_W-1:0]    idx_q;
	logic [1:0]          status_q;
	logic [ID_WIDTH-1:0] taken_q;
	logic                out_valid_q;

	logic [PTR_W-1:0]    idx_phys;
	logic [PTR_W-1:0]    idx_next_phys;
	logic [PTR_W-1:0]    tail_phys;
	logic                in_fire;
	logic                limit_hit;

	assign in_fire       = in_valid && in_ready;
	assign in_ready      = (state_q == S_IDLE) && !out_valid_q;
	assign idx_phys      = head_q + idx_q[PTR_W-1:0];
	assign idx_next_phys = idx_phys + PTR_W'(1);
	assign tail_phys     = head_q + count_q[PTR_W-1:0];
	assign limit_hit     = (count_q == CNT_W'(QUEUE_DEPTH)) ||
		((count_q != '0) && ({1'b0, count_q} >= (CNT_W+1)'(limit_q)));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_phys;
		wr_en   = 1'b0;
		wr_addr = tail_phys;
		wr_data = id_q;
		case (state_q)
			S_IDLE: begin
				rd_en   = in_fire;
				rd_addr = head_q;
			end
			S_ADD: wr_en = !limit_hit;
			// next head, needed when the current head is dead
			S_TAKE: begin
				rd_en   = 1'b1;
				rd_addr = head_q + PTR_W'(1);
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_next_phys;
			end
			S_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_next_phys;
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_phys;
				wr_data = rd_data_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dead_q      <= '0;
			head_q      <= '0;
			count_q     <= '0;
			limit_q     <= 6'd16;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_ADD;
			idx_q       <= '0;
			id_q        <= '0;
			taken_q     <= '0;
			status_q    <= ST_OK;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cmd_q    <= cmd_t'(command);
						id_q     <= circuit_id;
						idx_q    <= '0;
						taken_q  <= '0;
						status_q <= ST_OK;
						case (cmd_t'(command))
							CMD_ADD:  state_q <= S_ADD;
							CMD_TAKE: state_q <= S_TAKE;
							default:  state_q <= S_SCAN;
						endcase
					end
				end
				S_ADD: begin
					if (limit_hit) begin
						status_q <= ST_FULL;
					end else begin
						dead_q[tail_phys] <= 1'b0;
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_TAKE: begin
					if (count_q == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else begin
						dead_q[head_q] <= 1'b0;
						head_q  <= head_q + PTR_W'(1);
						count_q <= count_q - CNT_W'(1);
						if (dead_q[head_q]) begin
							if (count_q == CNT_W'(1)) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_TAKE;
							end
						end else begin
							taken_q <= rd_data_q;
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (idx_q >= count_q) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_DONE;
					end else if (rd_data_q == id_q) begin
						if (cmd_q == CMD_MARK) begin
							dead_q[idx_phys] <= 1'b1;
							state_q <= S_DONE;
						end else if (idx_q + CNT_W'(1) >= count_q) begin
							dead_q[idx_phys] <= 1'b0;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHIFT_WR;
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					dead_q[idx_phys] <= dead_q[idx_next_phys];
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q + CNT_W'(2) >= count_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign taken_id  = taken_q;
	assign occupancy = 6'(count_q);

	`ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == S_DONE, out_valid_q)
endmodule
